// ----- hdl/mba_pkg.sv -----
// Shared types and constants for the max-bandwidth minimum arborescence unit.
package mba_pkg;

  localparam int MAX_NODES_DEF = 64;
  localparam int MAX_EDGES_DEF = 16384;
  localparam int ADDR_W        = 3;
  localparam int BW_W          = 20;
  localparam int COST_W        = 20;
  localparam int NCOUNT_W      = 7;
  localparam int BUDGET_W      = 30;
  localparam int ALU_W         = 32;

  // Register indexes, decoded from paddr[2].
  localparam logic REG_NODE_COUNT  = 1'b0;
  localparam logic REG_COST_BUDGET = 1'b1;

  typedef struct packed {
    logic [5:0]      edge_src;
    logic [5:0]      edge_dst;
    logic [BW_W-1:0] edge_bandwidth;
    logic [COST_W-1:0] edge_cost;
    logic            is_last;
  } in_t;

  typedef struct packed {
    logic            streaming_possible;
    logic [BW_W-1:0] best_bandwidth;
  } out_t;

  // One stored edge as loaded.
  typedef struct packed {
    logic [5:0]        src;
    logic [5:0]        dst;
    logic [BW_W-1:0]   bw;
    logic [COST_W-1:0] cost;
  } edge_rec_t;

  typedef enum logic [2:0] {
    ALU_ADD = 3'b001,
    ALU_SUB = 3'b010,
    ALU_LT  = 3'b100
  } alu_op_t;

endpackage

// ----- hdl/max_bandwidth_min_arborescence_unit.sv -----
// Max-bandwidth minimum arborescence unit: edge loader, search sequencer, config port.
// Loading takes one cycle per edge; busy stays low until the edge marked last arrives.
// The search then runs about log2(bandwidth range) probes; each probe copies the in-range
// edges, then runs scan, check and walk rounds, contracting whenever a round finds cycles,
// all on one shared ALU and dual-port node RAMs; done pulses for one cycle, no stall.
// Synchronous reset returns edge count, search bounds and config registers to reset values.
module max_bandwidth_min_arborescence_unit #(
  parameter int MAX_NODES = mba_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES = mba_pkg::MAX_EDGES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mba_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       start,
  input  mba_pkg::in_t               item,
  output logic                       busy,
  output logic                       done,
  output mba_pkg::out_t              result
);

  localparam int NW   = $clog2(MAX_NODES) + 1;
  localparam int NA   = $clog2(MAX_NODES);
  localparam int EW   = $clog2(MAX_EDGES + 1);
  localparam int AW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int BW_W = mba_pkg::BW_W;
  localparam int CW   = mba_pkg::COST_W;
  localparam int WK_W = 2 * NW + BW_W + CW;
  localparam int ER_W = $bits(mba_pkg::edge_rec_t);
  localparam int XW   = mba_pkg::ALU_W;
  localparam logic [NW-1:0] NONE = NW'(MAX_NODES);

  typedef enum logic [30:0] {
    S_IDLE    = 31'd1 << 0,
    S_SINIT   = 31'd1 << 1,
    S_MID     = 31'd1 << 2,
    S_CP_RD   = 31'd1 << 3,
    S_CP_WR   = 31'd1 << 4,
    S_CLR     = 31'd1 << 5,
    S_SC_RD   = 31'd1 << 6,
    S_SC_NODE = 31'd1 << 7,
    S_SC_UPD  = 31'd1 << 8,
    S_CK_RD   = 31'd1 << 9,
    S_CK_TST  = 31'd1 << 10,
    S_INIT    = 31'd1 << 11,
    S_ROOT0   = 31'd1 << 12,
    S_CY_RD   = 31'd1 << 13,
    S_CY_ADD  = 31'd1 << 14,
    S_WK_RD   = 31'd1 << 15,
    S_WK_TST  = 31'd1 << 16,
    S_MK_TST  = 31'd1 << 17,
    S_MK_NXT  = 31'd1 << 18,
    S_LOOPEND = 31'd1 << 19,
    S_RL_RD   = 31'd1 << 20,
    S_RL_TST  = 31'd1 << 21,
    S_RM_RD   = 31'd1 << 22,
    S_RM_SRC  = 31'd1 << 23,
    S_RM_DST  = 31'd1 << 24,
    S_RM_WR   = 31'd1 << 25,
    S_RT_RD   = 31'd1 << 26,
    S_RT_WR   = 31'd1 << 27,
    S_EVAL    = 31'd1 << 28,
    S_FAIL    = 31'd1 << 29,
    S_DONE    = 31'd1 << 30
  } state_t;

  state_t state;

  // Configuration and loader registers.
  logic [mba_pkg::NCOUNT_W-1:0] node_count;
  logic [mba_pkg::BUDGET_W-1:0] cost_budget;
  logic [EW-1:0]                edge_total;
  logic [BW_W-1:0]              search_low;
  logic [BW_W-1:0]              search_high;

  // Search and probe registers.
  logic signed [BW_W+1:0] lo;
  logic signed [BW_W+1:0] hi;
  logic [BW_W-1:0]        mid;
  logic [BW_W-1:0]        best;
  logic                   found;
  logic [EW-1:0]          ei;
  logic [EW-1:0]          w;
  logic [NW-1:0]          ni;
  logic [NW-1:0]          tn;
  logic [NW-1:0]          root;
  logic [NW-1:0]          k;
  logic [NW-1:0]          v;
  logic [NW-1:0]          cv;
  logic [NW-1:0]          j;
  logic [XW-1:0]          total;
  logic [NW-1:0]          ws;
  logic [NW-1:0]          wd;
  logic [BW_W-1:0]        wbw;
  logic [CW-1:0]          wc;
  logic [NW-1:0]          gs;

  // Memory ports.
  logic                st_we;
  logic [ER_W-1:0]     st_wdata;
  logic [ER_W-1:0]     st_rdata;
  mba_pkg::edge_rec_t  st_rd;
  logic                wk_we;
  logic [AW-1:0]       wk_waddr;
  logic [WK_W-1:0]     wk_wdata;
  logic [WK_W-1:0]     wk_rdata;
  logic [NW-1:0]       wk_src;
  logic [NW-1:0]       wk_dst;
  logic [BW_W-1:0]     wk_bw;
  logic [CW-1:0]       wk_cost;
  logic [NW-1:0]       naddr;
  logic [NW-1:0]       nwaddr;
  logic                has_we;
  logic                has_wdata;
  logic                has_rd;
  logic                min_we;
  logic [CW-1:0]       min_wdata;
  logic [CW-1:0]       min_rd;
  logic                pred_we;
  logic [NW-1:0]       pred_rd;
  logic                grp_we;
  logic [NW-1:0]       grp_wdata;
  logic [NW-1:0]       grp_rd;
  logic                vis_we;
  logic [NW-1:0]       vis_rd;

  // Shared ALU ports.
  mba_pkg::alu_op_t    alu_op;
  logic signed [XW-1:0] alu_a;
  logic signed [XW-1:0] alu_b;
  logic signed [XW-1:0] alu_y;

  logic [NW-1:0]   n_used;
  logic            room;
  logic [BW_W-1:0] low_eff;
  logic [BW_W-1:0] high_eff;
  logic            in_range;
  logic            sc_take;
  logic            walk_on;

  // APB configuration port.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count  <= mba_pkg::NCOUNT_W'(1);
      cost_budget <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        mba_pkg::REG_NODE_COUNT:  node_count  <= pwdata[mba_pkg::NCOUNT_W-1:0];
        mba_pkg::REG_COST_BUDGET: cost_budget <= pwdata[mba_pkg::BUDGET_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      mba_pkg::REG_NODE_COUNT:  prdata = 32'(node_count);
      mba_pkg::REG_COST_BUDGET: prdata = 32'(cost_budget);
      default:                  prdata = '0;
    endcase
  end

  // Effective node count: zero acts as one, large values clamp.
  always_comb begin
    if (node_count == '0) begin
      n_used = NW'(1);
    end else if (32'(node_count) > 32'(MAX_NODES)) begin
      n_used = NONE;
    end else begin
      n_used = NW'(node_count);
    end
  end

  // Loader bookkeeping for the current transaction.
  assign room     = edge_total < EW'(MAX_EDGES);
  assign low_eff  = (room && item.edge_bandwidth < search_low) ? item.edge_bandwidth
                                                               : search_low;
  assign high_eff = (room && item.edge_bandwidth > search_high) ? item.edge_bandwidth
                                                                : search_high;
  assign st_wdata = {item.edge_src, item.edge_dst, item.edge_bandwidth, item.edge_cost};
  assign st_rd    = mba_pkg::edge_rec_t'(st_rdata);
  assign in_range = (32'(st_rd.src) < 32'(n_used)) && (32'(st_rd.dst) < 32'(n_used));

  // Working edge record fields.
  assign wk_src  = wk_rdata[WK_W-1 -: NW];
  assign wk_dst  = wk_rdata[WK_W-NW-1 -: NW];
  assign wk_bw   = wk_rdata[CW +: BW_W];
  assign wk_cost = wk_rdata[CW-1:0];

  assign sc_take = (ws != wd) && (wbw >= mid) && (!has_rd || alu_y[0]);
  assign walk_on = (vis_rd != ni) && (grp_rd == NONE) && (v != root);

  mba_ram #(.WIDTH(ER_W), .DEPTH(MAX_EDGES), .AW(AW)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (edge_total[AW-1:0]),
    .wdata (st_wdata),
    .raddr (ei[AW-1:0]),
    .rdata (st_rdata)
  );

  mba_ram #(.WIDTH(WK_W), .DEPTH(MAX_EDGES), .AW(AW)) u_work (
    .clk   (clk),
    .we    (wk_we),
    .waddr (wk_waddr),
    .wdata (wk_wdata),
    .raddr (ei[AW-1:0]),
    .rdata (wk_rdata)
  );

  mba_ram #(.WIDTH(1), .DEPTH(MAX_NODES), .AW(NA)) u_has (
    .clk   (clk),
    .we    (has_we),
    .waddr (nwaddr[NA-1:0]),
    .wdata (has_wdata),
    .raddr (naddr[NA-1:0]),
    .rdata (has_rd)
  );

  mba_ram #(.WIDTH(CW), .DEPTH(MAX_NODES), .AW(NA)) u_min (
    .clk   (clk),
    .we    (min_we),
    .waddr (nwaddr[NA-1:0]),
    .wdata (min_wdata),
    .raddr (naddr[NA-1:0]),
    .rdata (min_rd)
  );

  mba_ram #(.WIDTH(NW), .DEPTH(MAX_NODES), .AW(NA)) u_pred (
    .clk   (clk),
    .we    (pred_we),
    .waddr (nwaddr[NA-1:0]),
    .wdata (ws),
    .raddr (naddr[NA-1:0]),
    .rdata (pred_rd)
  );

  mba_ram #(.WIDTH(NW), .DEPTH(MAX_NODES), .AW(NA)) u_group (
    .clk   (clk),
    .we    (grp_we),
    .waddr (nwaddr[NA-1:0]),
    .wdata (grp_wdata),
    .raddr (naddr[NA-1:0]),
    .rdata (grp_rd)
  );

  mba_ram #(.WIDTH(NW), .DEPTH(MAX_NODES), .AW(NA)) u_visit (
    .clk   (clk),
    .we    (vis_we),
    .waddr (nwaddr[NA-1:0]),
    .wdata ((state == S_INIT) ? NONE : ni),
    .raddr (naddr[NA-1:0]),
    .rdata (vis_rd)
  );

  mba_alu u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  // Memory strobes, addresses and ALU operands for each sequencer step.
  always_comb begin
    st_we     = 1'b0;
    wk_we     = 1'b0;
    wk_waddr  = ei[AW-1:0];
    wk_wdata  = {NW'(st_rd.src), NW'(st_rd.dst), st_rd.bw, st_rd.cost};
    naddr     = ni;
    nwaddr    = ni;
    has_we    = 1'b0;
    has_wdata = 1'b0;
    min_we    = 1'b0;
    min_wdata = wc;
    pred_we   = 1'b0;
    grp_we    = 1'b0;
    grp_wdata = NONE;
    vis_we    = 1'b0;
    alu_op    = mba_pkg::ALU_ADD;
    alu_a     = '0;
    alu_b     = '0;
    case (state)
      S_IDLE: begin
        st_we = start && room;
      end
      S_SINIT: begin
        alu_op = mba_pkg::ALU_LT;
        alu_a  = XW'(hi);
        alu_b  = XW'(lo);
      end
      S_MID: begin
        alu_a = XW'(lo);
        alu_b = XW'(hi);
      end
      S_CP_WR: begin
        wk_we    = in_range;
        wk_waddr = w[AW-1:0];
      end
      S_CLR: begin
        has_we = (ni != tn);
      end
      S_SC_NODE: begin
        naddr = wk_dst;
      end
      S_SC_UPD: begin
        alu_op    = mba_pkg::ALU_LT;
        alu_a     = XW'(wc);
        alu_b     = XW'(min_rd);
        nwaddr    = wd;
        has_we    = sc_take;
        has_wdata = 1'b1;
        min_we    = sc_take;
        pred_we   = sc_take;
      end
      S_INIT: begin
        grp_we = (ni != tn);
        vis_we = (ni != tn);
      end
      S_ROOT0: begin
        nwaddr    = root;
        min_we    = 1'b1;
        min_wdata = '0;
      end
      S_CY_ADD: begin
        alu_a = total;
        alu_b = XW'(min_rd);
      end
      S_WK_RD: begin
        naddr = v;
      end
      S_WK_TST: begin
        nwaddr = v;
        vis_we = walk_on;
      end
      S_MK_TST: begin
        naddr     = j;
        nwaddr    = j;
        grp_we    = 1'b1;
        grp_wdata = k;
      end
      S_RL_TST: begin
        grp_we    = (grp_rd == NONE);
        grp_wdata = k;
      end
      S_RM_SRC: begin
        naddr = wk_src;
      end
      S_RM_DST: begin
        naddr = wd;
      end
      S_RM_WR: begin
        alu_op   = mba_pkg::ALU_SUB;
        alu_a    = XW'(wc);
        alu_b    = XW'(min_rd);
        wk_we    = 1'b1;
        wk_wdata = {gs, grp_rd, wbw, (gs != grp_rd) ? alu_y[CW-1:0] : wc};
      end
      S_RT_RD: begin
        naddr = root;
      end
      S_EVAL: begin
        alu_op = mba_pkg::ALU_LT;
        alu_a  = XW'(cost_budget);
        alu_b  = total;
      end
      default: ;
    endcase
  end

  // Sequencer: loader, binary search and the contraction rounds of each probe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      edge_total  <= '0;
      search_low  <= '1;
      search_high <= '0;
      found       <= 1'b0;
      best        <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            if (room) begin
              edge_total  <= edge_total + EW'(1);
              search_low  <= low_eff;
              search_high <= high_eff;
            end
            if (item.is_last) begin
              lo    <= $signed({2'b00, low_eff});
              hi    <= $signed({2'b00, high_eff});
              found <= 1'b0;
              best  <= '0;
              state <= S_SINIT;
            end
          end
        end
        S_SINIT: begin
          state <= alu_y[0] ? S_DONE : S_MID;
        end
        S_MID: begin
          mid   <= alu_y[BW_W:1];
          ei    <= '0;
          w     <= '0;
          state <= S_CP_RD;
        end
        S_CP_RD: begin
          if (ei == edge_total) begin
            tn    <= n_used;
            root  <= '0;
            total <= '0;
            ni    <= '0;
            state <= S_CLR;
          end else begin
            state <= S_CP_WR;
          end
        end
        S_CP_WR: begin
          if (in_range) begin
            w <= w + EW'(1);
          end
          ei    <= ei + EW'(1);
          state <= S_CP_RD;
        end
        S_CLR: begin
          if (ni == tn) begin
            ei    <= '0;
            state <= S_SC_RD;
          end else begin
            ni <= ni + NW'(1);
          end
        end
        S_SC_RD: begin
          if (ei == w) begin
            ni    <= '0;
            state <= S_CK_RD;
          end else begin
            state <= S_SC_NODE;
          end
        end
        S_SC_NODE: begin
          ws    <= wk_src;
          wd    <= wk_dst;
          wbw   <= wk_bw;
          wc    <= wk_cost;
          state <= S_SC_UPD;
        end
        S_SC_UPD: begin
          ei    <= ei + EW'(1);
          state <= S_SC_RD;
        end
        S_CK_RD: begin
          if (ni == tn) begin
            ni    <= '0;
            state <= S_INIT;
          end else begin
            state <= S_CK_TST;
          end
        end
        S_CK_TST: begin
          if (ni != root && !has_rd) begin
            state <= S_FAIL;
          end else begin
            ni    <= ni + NW'(1);
            state <= S_CK_RD;
          end
        end
        S_INIT: begin
          if (ni == tn) begin
            state <= S_ROOT0;
          end else begin
            ni <= ni + NW'(1);
          end
        end
        S_ROOT0: begin
          ni    <= '0;
          k     <= '0;
          state <= S_CY_RD;
        end
        S_CY_RD: begin
          state <= (ni == tn) ? S_LOOPEND : S_CY_ADD;
        end
        S_CY_ADD: begin
          total <= alu_y;
          v     <= ni;
          state <= S_WK_RD;
        end
        S_WK_RD: begin
          state <= S_WK_TST;
        end
        S_WK_TST: begin
          if (walk_on) begin
            v     <= pred_rd;
            state <= S_WK_RD;
          end else if (v != root && grp_rd == NONE) begin
            cv    <= v;
            j     <= pred_rd;
            state <= S_MK_TST;
          end else begin
            ni    <= ni + NW'(1);
            state <= S_CY_RD;
          end
        end
        S_MK_TST: begin
          if (j != cv) begin
            state <= S_MK_NXT;
          end else begin
            k     <= k + NW'(1);
            ni    <= ni + NW'(1);
            state <= S_CY_RD;
          end
        end
        S_MK_NXT: begin
          j     <= pred_rd;
          state <= S_MK_TST;
        end
        S_LOOPEND: begin
          if (k == '0) begin
            state <= S_EVAL;
          end else begin
            ni    <= '0;
            state <= S_RL_RD;
          end
        end
        S_RL_RD: begin
          if (ni == tn) begin
            ei    <= '0;
            state <= S_RM_RD;
          end else begin
            state <= S_RL_TST;
          end
        end
        S_RL_TST: begin
          if (grp_rd == NONE) begin
            k <= k + NW'(1);
          end
          ni    <= ni + NW'(1);
          state <= S_RL_RD;
        end
        S_RM_RD: begin
          state <= (ei == w) ? S_RT_RD : S_RM_SRC;
        end
        S_RM_SRC: begin
          ws    <= wk_src;
          wd    <= wk_dst;
          wbw   <= wk_bw;
          wc    <= wk_cost;
          state <= S_RM_DST;
        end
        S_RM_DST: begin
          gs    <= grp_rd;
          state <= S_RM_WR;
        end
        S_RM_WR: begin
          ei    <= ei + EW'(1);
          state <= S_RM_RD;
        end
        S_RT_RD: begin
          state <= S_RT_WR;
        end
        S_RT_WR: begin
          root  <= grp_rd;
          tn    <= k;
          ni    <= '0;
          state <= S_CLR;
        end
        S_EVAL: begin
          if (alu_y[0]) begin
            state <= S_FAIL;
          end else begin
            lo    <= $signed({2'b00, mid}) + 22'sd1;
            best  <= mid;
            found <= 1'b1;
            state <= S_SINIT;
          end
        end
        S_FAIL: begin
          hi    <= $signed({2'b00, mid}) - 22'sd1;
          state <= S_SINIT;
        end
        S_DONE: begin
          edge_total  <= '0;
          search_low  <= '1;
          search_high <= '0;
          state       <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Handshake and result.
  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);
  assign result.streaming_possible = found;
  assign result.best_bandwidth     = found ? best : '0;

`ifndef SYNTHESIS
  a_load_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !item.is_last) |=> !busy)
    else $error("edge load without last flag left idle");

  a_done_returns: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("result transaction not followed by idle");

  a_edge_cap: assert property (@(posedge clk) disable iff (rst)
    edge_total <= EW'(MAX_EDGES))
    else $error("edge count beyond memory depth");

  a_result_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.streaming_possible) |-> (result.best_bandwidth == '0))
    else $error("nonzero bandwidth reported without a feasible threshold");

  a_scan_node: assert property (@(posedge clk) disable iff (rst)
    (state == S_SC_UPD) |-> (wd < tn))
    else $error("scan destination outside current node range");
`endif

endmodule

// ----- hdl/mba_ram.sv -----
// Simple dual-port RAM with one write port and one registered read port.
module mba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read first: a read of the address being written returns the old word; read data registered.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/mba_alu.sv -----
// Shared adder, subtractor and signed comparator used by the search sequencer.
module mba_alu (
  input  mba_pkg::alu_op_t                   op,
  input  logic signed [mba_pkg::ALU_W-1:0]   a,
  input  logic signed [mba_pkg::ALU_W-1:0]   b,
  output logic signed [mba_pkg::ALU_W-1:0]   y
);

  // One operation per cycle, selected by the sequencer.
  always_comb begin
    case (op)
      mba_pkg::ALU_ADD: y = a + b;
      mba_pkg::ALU_SUB: y = a - b;
      mba_pkg::ALU_LT:  y = {{(mba_pkg::ALU_W-1){1'b0}}, (a < b)};
      default:          y = '0;
    endcase
  end

endmodule

// ----- sim/max_bandwidth_min_arborescence_unit_tb.sv -----
// Testbench for the max-bandwidth minimum arborescence unit: directed table, random graphs.
module max_bandwidth_min_arborescence_unit_tb;

  // The unit is built with a small edge memory so that the full-memory case fills quickly.
  localparam int EDGE_CAP   = 256;
  localparam int NODE_CAP   = mba_pkg::MAX_NODES_DEF;
  localparam int NO_GROUP   = NODE_CAP;
  localparam int IDLE_LIMIT = 64000000;
  localparam int RAND_ITEMS = 580;

  typedef enum logic {ROW_EDGE, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t     kind;
    logic          reg_idx;
    int unsigned   reg_val;
    mba_pkg::in_t  edge_in;
    bit            typed;
    mba_pkg::out_t typed_res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [mba_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start = 1'b0;
  mba_pkg::in_t item = '0;
  logic        busy;
  logic        done;
  mba_pkg::out_t result;

  int   errors = 0;
  int   idle_cycles = 0;
  int   edges_sent = 0;
  mba_pkg::out_t verdict_q[$];

  // Model copy of the configuration and the loaded graph.
  int unsigned cfg_nodes = 1;
  int unsigned cfg_budget = 0;
  int   mem_src[EDGE_CAP];
  int   mem_dst[EDGE_CAP];
  int   mem_bw[EDGE_CAP];
  int   mem_cost[EDGE_CAP];
  int   mem_count = 0;
  int   bw_floor = 32'hFFFFF;
  int   bw_ceil = 0;

  // Per-probe scratch of the contraction loop.
  int     w_src[EDGE_CAP];
  int     w_dst[EDGE_CAP];
  int     w_bw[EDGE_CAP];
  longint w_cost[EDGE_CAP];
  longint cheapest_in[NODE_CAP];
  bit     got_in[NODE_CAP];
  int     parent[NODE_CAP];
  int     group_of[NODE_CAP];
  int     walk_tag[NODE_CAP];

  max_bandwidth_min_arborescence_unit #(.MAX_EDGES(EDGE_CAP)) uut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .item(item), .busy(busy), .done(done), .result(result)
  );

  always #10 clk = ~clk;

  function automatic int active_nodes();
    if (cfg_nodes == 0) return 1;
    if (cfg_nodes > NODE_CAP) return NODE_CAP;
    return int'(cfg_nodes);
  endfunction

  // Minimum arborescence cost over edges at or above thr, or -1 if some node is unreachable.
  function automatic longint arborescence_cost(int thr);
    int n, w, tn, root, k, v, j, s, d, od;
    longint total;
    n = active_nodes();
    w = 0;
    tn = n;
    root = 0;
    total = 0;
    for (int i = 0; i < mem_count; i++) begin
      if (mem_src[i] < n && mem_dst[i] < n) begin
        w_src[w] = mem_src[i];
        w_dst[w] = mem_dst[i];
        w_bw[w] = mem_bw[i];
        w_cost[w] = mem_cost[i];
        w++;
      end
    end
    forever begin
      k = 0;
      for (int i = 0; i < tn; i++) got_in[i] = 1'b0;
      for (int i = 0; i < w; i++) begin
        s = w_src[i];
        d = w_dst[i];
        if (s != d && w_bw[i] >= thr && (!got_in[d] || w_cost[i] < cheapest_in[d])) begin
          got_in[d] = 1'b1;
          cheapest_in[d] = w_cost[i];
          parent[d] = s;
        end
      end
      for (int i = 0; i < tn; i++)
        if (i != root && !got_in[i]) return -1;
      for (int i = 0; i < tn; i++) begin
        group_of[i] = NO_GROUP;
        walk_tag[i] = NO_GROUP;
      end
      cheapest_in[root] = 0;
      // Walk predecessors from every node; a walk that closes on itself marks a cycle.
      for (int i = 0; i < tn; i++) begin
        v = i;
        total += cheapest_in[i];
        while (walk_tag[v] != i && group_of[v] == NO_GROUP && v != root) begin
          walk_tag[v] = i;
          v = parent[v];
        end
        if (v != root && group_of[v] == NO_GROUP) begin
          j = parent[v];
          while (j != v) begin
            group_of[j] = k;
            j = parent[j];
          end
          group_of[v] = k;
          k++;
        end
      end
      if (k == 0) return total;
      for (int i = 0; i < tn; i++)
        if (group_of[i] == NO_GROUP) group_of[i] = k++;
      // Contract the cycles and reduce the cost of edges entering them.
      for (int i = 0; i < w; i++) begin
        od = w_dst[i];
        w_src[i] = group_of[w_src[i]];
        w_dst[i] = group_of[od];
        if (w_src[i] != w_dst[i]) w_cost[i] -= cheapest_in[od];
      end
      tn = k;
      root = group_of[root];
    end
  endfunction

  // Loads one edge into the model; on the last edge runs the bandwidth search.
  task automatic absorb_edge(input mba_pkg::in_t e, output bit has_res,
                             output mba_pkg::out_t res);
    longint lo, hi, mid, c, best;
    if (mem_count < EDGE_CAP) begin
      mem_src[mem_count] = int'(e.edge_src);
      mem_dst[mem_count] = int'(e.edge_dst);
      mem_bw[mem_count] = int'(e.edge_bandwidth);
      mem_cost[mem_count] = int'(e.edge_cost);
      mem_count++;
      if (int'(e.edge_bandwidth) < bw_floor) bw_floor = int'(e.edge_bandwidth);
      if (int'(e.edge_bandwidth) > bw_ceil) bw_ceil = int'(e.edge_bandwidth);
    end
    has_res = e.is_last;
    res = '0;
    if (!e.is_last) return;
    lo = bw_floor;
    hi = bw_ceil;
    best = -1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      c = arborescence_cost(int'(mid));
      if (c < 0 || c > longint'(cfg_budget)) begin
        hi = mid - 1;
      end else begin
        lo = mid + 1;
        best = mid;
      end
    end
    res.streaming_possible = (best >= 0);
    res.best_bandwidth = (best >= 0) ? best[mba_pkg::BW_W-1:0] : '0;
    mem_count = 0;
    bw_floor = 32'hFFFFF;
    bw_ceil = 0;
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // APB write: setup cycle, then access cycle ending at the edge with pready high.
  task automatic write_reg(input logic idx, input int unsigned val);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == mba_pkg::REG_NODE_COUNT) cfg_nodes = val & 32'h7F;
    else cfg_budget = val & 32'h3FFFFFFF;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Holds the sender off until every pending verdict has arrived and the unit is idle.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (verdict_q.size() != 0 || busy) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // One edge transaction; gap is the number of idle cycles afterwards.
  task automatic send_edge(input mba_pkg::in_t e, input bit typed,
                           input mba_pkg::out_t typed_res, input int gap);
    bit            has_res;
    mba_pkg::out_t res;
    @(negedge clk);
    start <= 1'b1;
    item <= e;
    do @(posedge clk); while (busy);
    absorb_edge(e, has_res, res);
    if (has_res) verdict_q.push_back(typed ? typed_res : res);
    edges_sent++;
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  function automatic int pick_gap(bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic mba_pkg::in_t mk_edge(int s, int d, int bw, int cost, bit last);
    mba_pkg::in_t e;
    e.edge_src = 6'(s);
    e.edge_dst = 6'(d);
    e.edge_bandwidth = mba_pkg::BW_W'(bw);
    e.edge_cost = mba_pkg::COST_W'(cost);
    e.is_last = last;
    return e;
  endfunction

  function automatic stim_row_t edge_row(mba_pkg::in_t e, bit typed, bit ok, int bw);
    stim_row_t r;
    r.kind = ROW_EDGE;
    r.reg_idx = mba_pkg::REG_NODE_COUNT;
    r.reg_val = 0;
    r.edge_in = e;
    r.typed = typed;
    r.typed_res.streaming_possible = ok;
    r.typed_res.best_bandwidth = mba_pkg::BW_W'(bw);
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic idx, int unsigned val);
    stim_row_t r;
    r = edge_row('0, 1'b0, 1'b0, 0);
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // One random graph: mostly a spanning structure with random extras, sometimes pure noise.
  task automatic random_graph();
    mba_pkg::in_t edges[$];
    int   n, ne, base, span, extra, u;
    bit   shaped, burst, wide_cost;
    int unsigned budget;
    u = $urandom_range(0, 99);
    if (u < 80) n = $urandom_range(2, 8);
    else if (u < 90) n = $urandom_range(9, 64);
    else if (u < 95) n = 0;
    else n = $urandom_range(65, 127);
    ne = (n == 0) ? 1 : (n > NODE_CAP ? NODE_CAP : n);
    u = $urandom_range(0, 99);
    if (u < 30) budget = $urandom_range(0, ne * 600);
    else if (u < 50) budget = 0;
    else if (u < 80) budget = $urandom_range(0, 32'h3FFFFFFF);
    else budget = 32'h3FFFFFFF;
    drain();
    write_reg(mba_pkg::REG_NODE_COUNT, n);
    write_reg(mba_pkg::REG_COST_BUDGET, budget);
    shaped = ($urandom_range(0, 99) < 70);
    burst = ($urandom_range(0, 3) == 0);
    wide_cost = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 1)) begin
      base = $urandom_range(0, 32'hFFFFF - 63);
      span = 63;
    end else begin
      base = 0;
      span = 32'hFFFFF;
    end
    if (shaped) begin
      for (int v = 1; v < ne; v++) begin
        u = $urandom_range(0, ne - 1);
        if (u == v) u = 0;
        edges.push_back(mk_edge(u, v, base + $urandom_range(0, span),
                                wide_cost ? $urandom_range(0, 32'hFFFFF) : $urandom_range(0, 1000),
                                1'b0));
      end
      extra = $urandom_range(0, 2 * ne);
      for (int x = 0; x < extra; x++)
        edges.push_back(mk_edge($urandom_range(0, ne - 1), $urandom_range(0, ne - 1),
                                base + $urandom_range(0, span),
                                wide_cost ? $urandom_range(0, 32'hFFFFF) : $urandom_range(0, 1000),
                                1'b0));
      if ($urandom_range(0, 3) == 0)
        edges.push_back(mk_edge($urandom_range(0, 63), $urandom_range(0, 63),
                                $urandom_range(0, 32'hFFFFF), $urandom_range(0, 32'hFFFFF),
                                1'b0));
      edges.shuffle();
    end else begin
      extra = $urandom_range(1, 12);
      for (int x = 0; x < extra; x++)
        edges.push_back(mk_edge($urandom_range(0, 63), $urandom_range(0, 63),
                                $urandom_range(0, 32'hFFFFF), $urandom_range(0, 32'hFFFFF),
                                1'b0));
    end
    if (edges.size() == 0)
      edges.push_back(mk_edge(0, 0, base, 0, 1'b0));
    edges[edges.size() - 1].is_last = 1'b1;
    foreach (edges[i]) send_edge(edges[i], 1'b0, '0, pick_gap(burst));
  endtask

  // Compare every verdict with the oldest pending expectation.
  always @(posedge clk) begin
    mba_pkg::out_t want;
    if (!rst && done) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("verdict with none pending");
      end else begin
        want = verdict_q.pop_front();
        if (result.streaming_possible !== want.streaming_possible)
          report_mismatch($sformatf("streaming_possible %0b, want %0b",
                                    result.streaming_possible, want.streaming_possible));
        if (result.best_bandwidth !== want.best_bandwidth)
          report_mismatch($sformatf("best_bandwidth %0h, want %0h",
                                    result.best_bandwidth, want.best_bandwidth));
      end
    end
  end

  // Watchdog on cycles with no transaction on either side.
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[max_bandwidth_min_arborescence_unit] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    stim_row_t plan[$];
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: reset settings, cycles, self loops, out-of-range endpoints and counts.
    plan.push_back(edge_row(mk_edge(0, 0, 0, 0, 1'b1), 1'b1, 1'b1, 0));
    plan.push_back(edge_row(mk_edge(63, 63, 32'hFFFFF, 32'hFFFFF, 1'b1), 1'b1, 1'b1, 32'hFFFFF));
    plan.push_back(cfg_row(mba_pkg::REG_NODE_COUNT, 3));
    plan.push_back(cfg_row(mba_pkg::REG_COST_BUDGET, 32'h3FFFFFFF));
    plan.push_back(edge_row(mk_edge(0, 1, 10, 7, 1'b0), 1'b0, 1'b0, 0));
    plan.push_back(edge_row(mk_edge(1, 2, 20, 3, 1'b0), 1'b0, 1'b0, 0));
    plan.push_back(edge_row(mk_edge(2, 1, 30, 1, 1'b0), 1'b0, 1'b0, 0));
    plan.push_back(edge_row(mk_edge(2, 2, 40, 0, 1'b0), 1'b0, 1'b0, 0));
    plan.push_back(edge_row(mk_edge(5, 2, 32'hFFFFF, 0, 1'b0), 1'b0, 1'b0, 0));
    plan.push_back(edge_row(mk_edge(0, 2, 15, 32'hFFFFF, 1'b1), 1'b0, 1'b0, 0));
    plan.push_back(cfg_row(mba_pkg::REG_COST_BUDGET, 0));
    plan.push_back(edge_row(mk_edge(0, 1, 5, 1, 1'b0), 1'b0, 1'b0, 0));
    plan.push_back(edge_row(mk_edge(0, 2, 5, 0, 1'b1), 1'b1, 1'b0, 0));
    plan.push_back(cfg_row(mba_pkg::REG_NODE_COUNT, 0));
    plan.push_back(edge_row(mk_edge(3, 4, 7, 9, 1'b1), 1'b1, 1'b1, 7));
    plan.push_back(cfg_row(mba_pkg::REG_NODE_COUNT, 127));
    plan.push_back(edge_row(mk_edge(0, 1, 9, 0, 1'b1), 1'b1, 1'b0, 0));
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        drain();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_edge(plan[i].edge_in, plan[i].typed, plan[i].typed_res, pick_gap(1'b0));
      end
    end

    // Full edge memory: the overflow edge is dropped and must not widen the bounds.
    drain();
    write_reg(mba_pkg::REG_NODE_COUNT, 2);
    write_reg(mba_pkg::REG_COST_BUDGET, 32'h3FFFFFFF);
    send_edge(mk_edge(0, 1, 100, 5, 1'b0), 1'b0, '0, 0);
    for (int i = 1; i < EDGE_CAP; i++)
      send_edge(mk_edge(63, 63, 100, 0, 1'b0), 1'b0, '0, 0);
    send_edge(mk_edge(0, 1, 0, 0, 1'b1), 1'b1,
              '{streaming_possible: 1'b1, best_bandwidth: 20'd100}, 0);

    // Random graphs.
    edges_sent = 0;
    while (edges_sent < RAND_ITEMS) random_graph();

    @(negedge clk);
    start <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (verdict_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("[max_bandwidth_min_arborescence_unit] OK");
    end else begin
      $display("[max_bandwidth_min_arborescence_unit] ERROR");
    end
    $finish;
  end

endmodule
